// File: rtl/swmm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sliding window min/max core.
// No dependencies; imported by every module of the block.
package swmm_pkg;

   localparam int WINDOW_MAX_DEF = 1024;
   localparam int SAMPLE_W       = 32;
   localparam int WLEN_W         = 11;
   localparam int BEST_W         = 32;

   typedef logic [2:0] cell_op_type;

   localparam cell_op_type OP_HOLD       = 3'd0;
   localparam cell_op_type OP_STEP       = 3'd1;
   localparam cell_op_type OP_SHIFT_DOWN = 3'd2;
   localparam cell_op_type OP_SHIFT_UP   = 3'd3;
   localparam cell_op_type OP_CLEAR      = 3'd4;

   typedef struct packed {
      logic                        valid;
      logic signed [SAMPLE_W-1:0]  min_val;
      logic signed [SAMPLE_W-1:0]  max_val;
   } cell_entry_type;

   typedef struct packed {
      cell_op_type                 op;
      logic signed [SAMPLE_W-1:0]  sample;
   } cell_ctrl_type;

endpackage

// File: rtl/swmm_cell.sv
`timescale 1ns / 1ps
// One cell of the window row: min and max over the samples that stay in the
// window for at least IDX more words. Depends on swmm_pkg.
module swmm_cell #(
   parameter int IDX = 0,
   parameter int EW  = 11
) (
   input  logic                    clock,
   input  logic                    reset,
   input  swmm_pkg::cell_ctrl_type  ctrl,
   input  logic [EW-1:0]           eff_w,
   input  swmm_pkg::cell_entry_type up_entry,
   input  swmm_pkg::cell_entry_type down_entry,
   output swmm_pkg::cell_entry_type entry
);
   import swmm_pkg::*;

   cell_entry_type entry_ff;
   cell_entry_type entry_in;
   logic           in_win;

   assign in_win = EW'(IDX) < eff_w;
   assign entry  = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      case (ctrl.op)
         OP_HOLD: begin
            entry_in = entry_ff;
         end
         OP_STEP: begin
            entry_in.valid   = in_win;
            entry_in.min_val = (up_entry.valid && (up_entry.min_val < ctrl.sample)) ?
                               up_entry.min_val : ctrl.sample;
            entry_in.max_val = (up_entry.valid && (up_entry.max_val > ctrl.sample)) ?
                               up_entry.max_val : ctrl.sample;
         end
         OP_SHIFT_DOWN: begin
            entry_in = up_entry;
         end
         OP_SHIFT_UP: begin
            entry_in = down_entry;
         end
         OP_CLEAR: begin
            entry_in.valid = 1'b0;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff.min_val <= entry_in.min_val;
      entry_ff.max_val <= entry_in.max_val;
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
   end

endmodule

// File: rtl/swmm_chain.sv
`timescale 1ns / 1ps
// Row of WINDOW_MAX window cells; cell 0 holds the current window min/max.
// Depends on swmm_pkg and swmm_cell.
module swmm_chain #(
   parameter int WINDOW_MAX = swmm_pkg::WINDOW_MAX_DEF,
   parameter int EW         = 11
) (
   input  logic                    clock,
   input  logic                    reset,
   input  swmm_pkg::cell_ctrl_type  ctrl,
   input  logic [EW-1:0]           eff_w,
   output swmm_pkg::cell_entry_type head
);
   import swmm_pkg::*;

   cell_entry_type ent [WINDOW_MAX];

   assign head = ent[0];

   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      cell_entry_type up_e;
      cell_entry_type down_e;

      if (i == WINDOW_MAX - 1) begin : g_top
         assign up_e = '0;
      end else begin : g_mid
         assign up_e = ent[i+1];
      end

      if (i == 0) begin : g_bot
         assign down_e = ent[0];
      end else begin : g_upper
         assign down_e = ent[i-1];
      end

      swmm_cell #(
         .IDX (i),
         .EW  (EW)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .eff_w      (eff_w),
         .up_entry   (up_e),
         .down_entry (down_e),
         .entry      (ent[i])
      );
   end

endmodule

// File: rtl/sliding_window_min_max_core.sv
`timescale 1ns / 1ps
// Sliding window minimum and maximum over a stream of signed 32-bit words.
// Depends on swmm_pkg and swmm_chain.
//
// Input channel req_*: one word per sample, req_last_sample ends the stream.
// Result channel rsp_*: exactly one word per input word, in order.
// Both channels move a word at a clock edge with valid high and stall low.
// On acceptance the window cells step (a min and a max compare per cell);
// the pending stage then forms min + max, updates the running best into
// the output register and takes no word. A further word is taken while a
// finished result waits, so long as the receiver takes it by then.
// Receiver stall: the output word holds; req_stall rises until it is taken.
// csr_*: writes the window length (0 acts as 1, above WINDOW_MAX as
// WINDOW_MAX). A change of length realigns the cell row, one position per
// cycle; req_stall and csr_ready hold off meanwhile.
// Reset (synchronous): window length 1, all cells empty, best sum zero.
// The result flagged final clears the stream state after it is formed.
module sliding_window_min_max_core #(
   parameter int WINDOW_MAX = swmm_pkg::WINDOW_MAX_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [swmm_pkg::SAMPLE_W-1:0]   req_sample,
   input  logic                                   req_last_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [swmm_pkg::SAMPLE_W-1:0]   rsp_window_min,
   output logic signed [swmm_pkg::SAMPLE_W-1:0]   rsp_window_max,
   output logic                                   rsp_window_full,
   output logic        [swmm_pkg::BEST_W-1:0]     rsp_best_sum,
   output logic                                   rsp_is_final,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic        [swmm_pkg::WLEN_W-1:0]     csr_window_len
);
   import swmm_pkg::*;

   localparam int EW = $clog2(WINDOW_MAX + 1);

   logic [EW-1:0]              eff_w_ff, eff_w_in;
   logic [EW-1:0]              tgt_ff, tgt_in;
   logic [EW-1:0]              seen_ff, seen_in;
   logic                       pend_ff, pend_in;
   logic                       pend_last_ff, pend_last_in;
   logic [BEST_W-1:0]          best_ff, best_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] min_ff, max_ff;
   logic                       full_ff, final_ff;
   logic [BEST_W-1:0]          best_out_ff;

   logic                       busy, acc, csr_wr, full_now;
   logic [EW-1:0]              new_w;
   logic signed [SAMPLE_W:0]   sum;
   logic [BEST_W-1:0]          best_new;
   cell_ctrl_type              ctrl;
   cell_entry_type             head;

   assign busy      = eff_w_ff != tgt_ff;
   assign req_stall = pend_ff | busy | (rsp_valid_ff & rsp_stall);
   assign acc       = req_valid & ~req_stall;
   assign csr_ready = ~busy & ~pend_ff;
   assign csr_wr    = csr_valid & csr_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_window_min  = min_ff;
   assign rsp_window_max  = max_ff;
   assign rsp_window_full = full_ff;
   assign rsp_best_sum    = best_out_ff;
   assign rsp_is_final    = final_ff;

   // clamp the written length into 1..WINDOW_MAX
   always_comb begin
      if (csr_window_len == '0) begin
         new_w = EW'(1);
      end else if (32'(csr_window_len) > 32'(WINDOW_MAX)) begin
         new_w = EW'(WINDOW_MAX);
      end else begin
         new_w = EW'(csr_window_len);
      end
   end

   always_comb begin
      ctrl.sample = req_sample;
      if (pend_ff && pend_last_ff) begin
         ctrl.op = OP_CLEAR;
      end else if (acc) begin
         ctrl.op = OP_STEP;
      end else if (busy && (eff_w_ff > tgt_ff)) begin
         ctrl.op = OP_SHIFT_DOWN;
      end else if (busy) begin
         ctrl.op = OP_SHIFT_UP;
      end else begin
         ctrl.op = OP_HOLD;
      end
   end

   swmm_chain #(
      .WINDOW_MAX (WINDOW_MAX),
      .EW         (EW)
   ) u_chain (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .eff_w (eff_w_ff),
      .head  (head)
   );

   assign full_now = seen_ff >= eff_w_ff;
   assign sum      = (SAMPLE_W+1)'(head.min_val) + (SAMPLE_W+1)'(head.max_val);

   always_comb begin
      best_new = best_ff;
      if (full_now && !sum[SAMPLE_W] && (sum[BEST_W-1:0] > best_ff)) begin
         best_new = sum[BEST_W-1:0];
      end
   end

   always_comb begin
      eff_w_in     = eff_w_ff;
      tgt_in       = tgt_ff;
      seen_in      = seen_ff;
      pend_in      = pend_ff;
      pend_last_in = pend_last_ff;
      best_in      = best_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_wr) begin
         tgt_in = new_w;
      end
      if (busy && (eff_w_ff > tgt_ff)) begin
         eff_w_in = eff_w_ff - EW'(1);
      end else if (busy) begin
         eff_w_in = eff_w_ff + EW'(1);
      end
      if (acc) begin
         pend_in      = 1'b1;
         pend_last_in = req_last_sample;
         if (seen_ff < EW'(WINDOW_MAX)) begin
            seen_in = seen_ff + EW'(1);
         end
      end
      if (pend_ff) begin
         pend_in      = 1'b0;
         rsp_valid_in = 1'b1;
         best_in      = best_new;
         if (pend_last_ff) begin
            seen_in = '0;
            best_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_w_ff     <= EW'(1);
         tgt_ff       <= EW'(1);
         seen_ff      <= '0;
         pend_ff      <= 1'b0;
         pend_last_ff <= 1'b0;
         best_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         eff_w_ff     <= eff_w_in;
         tgt_ff       <= tgt_in;
         seen_ff      <= seen_in;
         pend_ff      <= pend_in;
         pend_last_ff <= pend_last_in;
         best_ff      <= best_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // load the output word when the pending result completes
   always_ff @(posedge clock) begin
      if (pend_ff) begin
         min_ff      <= head.min_val;
         max_ff      <= head.max_val;
         full_ff     <= full_now;
         best_out_ff <= best_new;
         final_ff    <= pend_last_ff;
      end
   end

endmodule

// File: tb/sliding_window_min_max_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for sliding_window_min_max_core: a clocked driver and monitor,
// with a running min/max deque predictor checked against every result word.
// Depends on swmm_pkg and the core RTL.
module sliding_window_min_max_core_tb;

   localparam int          WMAX        = swmm_pkg::WINDOW_MAX_DEF;
   localparam int          SW          = swmm_pkg::SAMPLE_W;
   localparam int          LW          = swmm_pkg::WLEN_W;
   localparam int          BW          = swmm_pkg::BEST_W;
   localparam int          RANDOM_WORDS = 400;
   localparam int unsigned CYCLE_LIMIT = 400000;

   typedef struct {
      logic signed [SW-1:0] sample;
      logic                 is_last;
   } sample_word_type;

   typedef struct {
      logic signed [SW-1:0] value;
      logic [31:0]          pos;
   } deque_slot_type;

   typedef struct {
      logic signed [SW-1:0] win_min;
      logic signed [SW-1:0] win_max;
      logic                 win_full;
      logic [BW-1:0]        best;
      logic                 is_last;
   } window_result_type;

   logic                 clock           = 1'b0;
   logic                 reset           = 1'b1;
   logic                 req_valid       = 1'b0;
   logic                 req_stall;
   logic signed [SW-1:0] req_sample      = '0;
   logic                 req_last_sample = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall       = 1'b0;
   logic signed [SW-1:0] rsp_window_min;
   logic signed [SW-1:0] rsp_window_max;
   logic                 rsp_window_full;
   logic [BW-1:0]        rsp_best_sum;
   logic                 rsp_is_final;
   logic                 csr_valid       = 1'b0;
   logic                 csr_ready;
   logic [LW-1:0]        csr_window_len  = '0;

   sample_word_type   pending_samples[$];
   window_result_type expected_windows[$];

   // predictor state
   logic [LW-1:0]  window_setting = LW'(1);
   deque_slot_type min_deque[$];
   deque_slot_type max_deque[$];
   logic [31:0]    next_pos     = '0;
   int unsigned    seen_samples = 0;
   longint         best_pair    = 0;

   int          mismatch_count = 0;
   int unsigned cycle_count    = 0;
   int          req_gap        = 0;
   int          rsp_hold       = 0;
   bit          req_bursty     = 1'b0;
   bit          rsp_bursty     = 1'b0;

   sliding_window_min_max_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .req_last_sample (req_last_sample),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_window_min  (rsp_window_min),
      .rsp_window_max  (rsp_window_max),
      .rsp_window_full (rsp_window_full),
      .rsp_best_sum    (rsp_best_sum),
      .rsp_is_final    (rsp_is_final),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_window_len  (csr_window_len)
   );

   always #5 clock = ~clock;

   function automatic window_result_type advance_window(input sample_word_type word);
      window_result_type r;
      logic [31:0]       w;
      deque_slot_type    slot;
      longint            pair;
      w = 32'(window_setting);
      if (w == 0) w = 1;
      if (w > WMAX) w = WMAX;
      while (min_deque.size() > 0 && (next_pos - min_deque[0].pos) >= w)
         min_deque.delete(0);
      while (max_deque.size() > 0 && (next_pos - max_deque[0].pos) >= w)
         max_deque.delete(0);
      while (min_deque.size() > 0 && word.sample <= min_deque[$].value)
         min_deque.delete(min_deque.size() - 1);
      while (max_deque.size() > 0 && word.sample >= max_deque[$].value)
         max_deque.delete(max_deque.size() - 1);
      slot.value = word.sample;
      slot.pos   = next_pos;
      min_deque.insert(min_deque.size(), slot);
      max_deque.insert(max_deque.size(), slot);
      if (seen_samples < WMAX) seen_samples++;
      next_pos++;
      r.win_min  = min_deque[0].value;
      r.win_max  = max_deque[0].value;
      r.win_full = (seen_samples >= w);
      if (r.win_full) begin
         pair = longint'(r.win_min) + longint'(r.win_max);
         if (pair > best_pair) best_pair = pair;
      end
      r.best    = best_pair[BW-1:0];
      r.is_last = word.is_last;
      if (word.is_last) begin
         min_deque.delete();
         max_deque.delete();
         next_pos     = '0;
         seen_samples = 0;
         best_pair    = 0;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string field, input longint got, input longint want);
      $display("mismatch on %0s at cycle %0d: got %0d, want %0d",
               field, cycle_count, got, want);
      mismatch_count++;
   endtask

   // driver
   always @(posedge clock) begin
      logic            nxt_valid;
      sample_word_type taken;
      nxt_valid = req_valid;
      if (reset) begin
         nxt_valid = 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            taken = pending_samples[0];
            pending_samples.delete(0);
            expected_windows.insert(expected_windows.size(), advance_window(taken));
            nxt_valid = 1'b0;
            if ($urandom_range(0, 23) == 0) req_bursty = ~req_bursty;
            req_gap = req_bursty ? 0 : $urandom_range(0, 16);
         end
         if (!nxt_valid) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_samples.size() > 0) begin
               nxt_valid = 1'b1;
               req_sample      <= pending_samples[0].sample;
               req_last_sample <= pending_samples[0].is_last;
            end
         end
      end
      req_valid <= nxt_valid;
   end

   // monitor
   always @(posedge clock) begin
      window_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_windows.size() == 0) begin
               report_mismatch("unexpected result word", 1, 0);
            end else begin
               want = expected_windows[0];
               expected_windows.delete(0);
               if (rsp_window_min !== want.win_min)
                  report_mismatch("window_min", longint'(rsp_window_min),
                                  longint'(want.win_min));
               if (rsp_window_max !== want.win_max)
                  report_mismatch("window_max", longint'(rsp_window_max),
                                  longint'(want.win_max));
               if (rsp_window_full !== want.win_full)
                  report_mismatch("window_full", longint'(rsp_window_full),
                                  longint'(want.win_full));
               if (rsp_best_sum !== want.best)
                  report_mismatch("best_sum", longint'(rsp_best_sum), longint'(want.best));
               if (rsp_is_final !== want.is_last)
                  report_mismatch("is_final", longint'(rsp_is_final),
                                  longint'(want.is_last));
            end
            if ($urandom_range(0, 23) == 0) rsp_bursty = ~rsp_bursty;
            rsp_hold = rsp_bursty ? 0 : $urandom_range(0, 16);
         end else if (rsp_hold > 0) begin
            rsp_hold--;
         end
         rsp_stall <= (rsp_hold > 0);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_samples.size() != 0 || req_valid || expected_windows.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic apply_window(input logic [LW-1:0] len);
      wait_drained();
      @(posedge clock);
      csr_valid      <= 1'b1;
      csr_window_len <= len;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      window_setting = len;
      @(negedge clock);
   endtask

   task automatic queue_sample(input logic signed [SW-1:0] s, input logic last);
      sample_word_type word;
      word.sample  = s;
      word.is_last = last;
      pending_samples.insert(pending_samples.size(), word);
   endtask

   function automatic logic signed [SW-1:0] draw_sample();
      case ($urandom_range(0, 5))
         0: return int'($urandom_range(0, 8)) - 4;
         1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         2: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF - $urandom_range(0, 3)
                                        : 32'sh8000_0000 + $urandom_range(0, 3);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [LW-1:0] draw_window();
      case ($urandom_range(0, 7))
         0: return LW'(0);
         1: return LW'(2047);
         2: return LW'($urandom_range(1023, 1025));
         3: return LW'($urandom_range(0, 2047));
         default: return LW'($urandom_range(1, 12));
      endcase
   endfunction

   initial begin
      int sent;
      int burst_len;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset length of one: extremes, overflowing pair sums
      queue_sample(32'sh7FFF_FFFF, 1'b0);
      queue_sample(32'sh8000_0000, 1'b0);
      queue_sample(0, 1'b0);
      queue_sample(-1, 1'b0);
      queue_sample(32'sh7FFF_FFFF, 1'b1);

      // zero length acts as one
      apply_window(LW'(0));
      queue_sample(7, 1'b0);
      queue_sample(-7, 1'b0);
      queue_sample(32'sh8000_0000, 1'b1);

      // filling window with ties and both orders, left open
      apply_window(LW'(3));
      queue_sample(5, 1'b0);
      queue_sample(3, 1'b0);
      queue_sample(3, 1'b0);
      queue_sample(7, 1'b0);
      queue_sample(-2, 1'b0);
      queue_sample(9, 1'b0);
      queue_sample(9, 1'b0);

      // shrink mid-stream: drop stale entries
      apply_window(LW'(2));
      queue_sample(-8, 1'b0);
      queue_sample(4, 1'b0);
      queue_sample(4, 1'b0);
      queue_sample(1, 1'b1);

      // oversize length clamps to the deepest window
      apply_window(LW'(2047));
      queue_sample(32'sh8000_0000, 1'b0);
      queue_sample(32'sh7FFF_FFFF, 1'b0);
      queue_sample(0, 1'b0);
      queue_sample(-5, 1'b0);
      queue_sample(6, 1'b0);

      sent = 0;
      while (sent < RANDOM_WORDS) begin
         apply_window(draw_window());
         burst_len = $urandom_range(5, 40);
         for (int i = 0; i < burst_len; i++) begin
            queue_sample(draw_sample(),
                         (i == burst_len - 1) ? ($urandom_range(0, 1) == 1)
                                              : ($urandom_range(0, 14) == 0));
         end
         sent += burst_len;
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: sliding_window_min_max_core.f
rtl/swmm_pkg.sv
rtl/swmm_cell.sv
rtl/swmm_chain.sv
rtl/sliding_window_min_max_core.sv
tb/sliding_window_min_max_core_tb.sv
